[hw/rtl/vtq_pkg.sv]
package vtq_pkg;

    typedef enum logic [1:0] {
        OP_RESOLVE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam int TIME_W  = 20;
    localparam int CORR_W  = 20;
    localparam int EFF_W   = 21;
    localparam int INDEX_W = 7;
    localparam int OCODE_W = 8;

    localparam logic [0:0] REG_STAGE_DELAY = 1'b0;

    localparam logic signed [TIME_W-1:0] STAGE_DELAY_RESET = 20'sd256;
    localparam logic signed [EFF_W-1:0]  STAGE0_NOMINAL    = 21'sd768;
    localparam logic signed [EFF_W-1:0]  STAGE1_NOMINAL    = 21'sd256;

endpackage

[hw/rtl/vtq_if.sv]
interface vtq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic signed [vtq_pkg::TIME_W-1:0]    time_in;
    logic signed [vtq_pkg::CORR_W-1:0]    corr_value;
    logic                                 corr_side;
    logic [vtq_pkg::INDEX_W-1:0]          stage_index;

    modport source (output valid, opcode, time_in, corr_value, corr_side, stage_index,
                    input ready);
    modport sink (input valid, opcode, time_in, corr_value, corr_side, stage_index,
                  output ready);
endinterface

interface vtq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [vtq_pkg::OCODE_W-1:0]          add_code;
    logic [vtq_pkg::OCODE_W-1:0]          sub_code;
    logic signed [vtq_pkg::EFF_W-1:0]     delay_value;

    modport source (output valid, add_code, sub_code, delay_value, input ready);
    modport sink (input valid, add_code, sub_code, delay_value, output ready);
endinterface

[hw/rtl/vtq_ram.sv]
module vtq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/vernier_tdc_quantizer.sv]
// Vernier time quantizer with per-stage calibration held in two correction
// RAMs (positive and negative stages). A resolve request walks the stages one
// RAM read per cycle and then loads its result into the output register from
// the DONE state; a read request passes through FETCH before DONE, and a write,
// an unused request or a read of a stage index of STAGES or more goes straight
// to DONE. Loading waits while an earlier result is still held in the output
// register, and the next request can be accepted in the cycle after the load.
// After reset the block clears both RAMs at every address and accepts no
// request until then; the stage_delay register can be written at any time the
// block is idle and resets to 1.0.
module vernier_tdc_quantizer #(
    parameter int CODE_BITS = 8,
    parameter int STAGES    = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    vtq_req_if.sink           req,
    vtq_rsp_if.source         rsp
);

    localparam int AW     = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int CW     = CODE_BITS - 1;
    localparam int VMAX   = (1 << (CODE_BITS - 1)) - 1;
    localparam int NWALK  = (VMAX < STAGES) ? VMAX : STAGES;
    localparam int LAST   = NWALK - 1;
    localparam int SUM_W  = vtq_pkg::EFF_W + AW + 1;

    vtq_pkg::state_t state_reg, state_next;

    logic signed [vtq_pkg::TIME_W-1:0] stage_delay_reg;
    logic [AW-1:0]                     clr_reg, clr_next;
    logic [AW-1:0]                     k_reg, k_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic signed [SUM_W-1:0]           sum_reg, sum_next;
    logic signed [vtq_pkg::TIME_W-1:0] t_reg, t_next;
    logic                              pos_reg, pos_next;
    logic                              side_reg, side_next;
    logic [AW-1:0]                     addr_reg, addr_next;

    logic [vtq_pkg::OCODE_W-1:0]       res_add_reg, res_add_next;
    logic [vtq_pkg::OCODE_W-1:0]       res_sub_reg, res_sub_next;
    logic signed [vtq_pkg::EFF_W-1:0]  res_delay_reg, res_delay_next;

    logic                              out_valid_reg, out_valid_next;
    logic [vtq_pkg::OCODE_W-1:0]       out_add_reg;
    logic [vtq_pkg::OCODE_W-1:0]       out_sub_reg;
    logic signed [vtq_pkg::EFF_W-1:0]  out_delay_reg;

    logic                              accept;
    logic                              in_range;
    logic                              out_load;
    logic                              plus_we, minus_we;
    logic [AW-1:0]                     waddr;
    logic [vtq_pkg::CORR_W-1:0]        wdata;
    logic [AW-1:0]                     raddr;
    logic [vtq_pkg::CORR_W-1:0]        plus_rdata, minus_rdata;

    logic [AW-1:0]                     eff_idx;
    logic                              eff_neg;
    logic signed [vtq_pkg::EFF_W-1:0]  nominal;
    logic signed [vtq_pkg::EFF_W-1:0]  corr;
    logic signed [vtq_pkg::EFF_W-1:0]  eff;
    logic                              step_hit;
    logic [CODE_BITS-1:0]              code_full;

    logic                              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == vtq_pkg::REG_STAGE_DELAY);

    always_comb
    begin
        if (paddr[2] == vtq_pkg::REG_STAGE_DELAY)
        begin
            prdata = 32'(stage_delay_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_delay_reg <= vtq_pkg::STAGE_DELAY_RESET;
        end
        else if (cfg_write)
        begin
            stage_delay_reg <= pwdata[vtq_pkg::TIME_W-1:0];
        end
    end

    assign req.ready = (state_reg == vtq_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_range  = 32'(req.stage_index) < 32'(STAGES);

    assign plus_we  = (state_reg == vtq_pkg::ST_CLEAR) ||
                      (accept && (req.opcode == vtq_pkg::OP_WRITE) && in_range && !req.corr_side);
    assign minus_we = (state_reg == vtq_pkg::ST_CLEAR) ||
                      (accept && (req.opcode == vtq_pkg::OP_WRITE) && in_range && req.corr_side);
    assign waddr    = (state_reg == vtq_pkg::ST_CLEAR) ? clr_reg : AW'(req.stage_index);
    assign wdata    = (state_reg == vtq_pkg::ST_CLEAR) ? '0 : req.corr_value;

    always_comb
    begin
        case (state_reg)
            vtq_pkg::ST_IDLE:
            begin
                if (req.opcode == vtq_pkg::OP_READ)
                begin
                    raddr = AW'(req.stage_index);
                end
                else
                begin
                    raddr = '0;
                end
            end
            vtq_pkg::ST_WALK:
            begin
                raddr = k_reg + AW'(1);
            end
            default:
            begin
                raddr = addr_reg;
            end
        endcase
    end

    vtq_ram #(.WIDTH(vtq_pkg::CORR_W), .DEPTH(STAGES)) u_plus_ram (
        .clk   (clk),
        .we    (plus_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (plus_rdata)
    );

    vtq_ram #(.WIDTH(vtq_pkg::CORR_W), .DEPTH(STAGES)) u_minus_ram (
        .clk   (clk),
        .we    (minus_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (minus_rdata)
    );

    assign eff_idx = (state_reg == vtq_pkg::ST_WALK) ? k_reg : addr_reg;
    assign eff_neg = (state_reg == vtq_pkg::ST_WALK) ? !pos_reg : side_reg;

    always_comb
    begin
        if (eff_neg)
        begin
            nominal = -vtq_pkg::EFF_W'(stage_delay_reg);
            corr    = vtq_pkg::EFF_W'(signed'(minus_rdata));
        end
        else
        begin
            corr = vtq_pkg::EFF_W'(signed'(plus_rdata));
            if (eff_idx == AW'(0))
            begin
                nominal = vtq_pkg::STAGE0_NOMINAL;
            end
            else if (eff_idx == AW'(1))
            begin
                nominal = vtq_pkg::STAGE1_NOMINAL;
            end
            else
            begin
                nominal = vtq_pkg::EFF_W'(stage_delay_reg);
            end
        end
    end

    assign eff      = nominal + corr;
    assign sum_next = sum_reg + SUM_W'(eff);
    assign step_hit = pos_reg ? (SUM_W'(t_reg) > sum_next) : (SUM_W'(t_reg) < sum_next);
    assign code_full = {1'b1, count_next};

    assign out_load = (state_reg == vtq_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        t_next         = t_reg;
        pos_next       = pos_reg;
        side_next      = side_reg;
        addr_next      = addr_reg;
        res_add_next   = res_add_reg;
        res_sub_next   = res_sub_reg;
        res_delay_next = res_delay_reg;
        case (state_reg)
            vtq_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STAGES - 1))
                begin
                    state_next = vtq_pkg::ST_IDLE;
                end
            end
            vtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_add_next   = '0;
                    res_sub_next   = '0;
                    res_delay_next = '0;
                    t_next         = req.time_in;
                    pos_next       = req.time_in > 0;
                    side_next      = req.corr_side;
                    addr_next      = AW'(req.stage_index);
                    k_next         = '0;
                    count_next     = '0;
                    state_next     = vtq_pkg::ST_DONE;
                    if (req.opcode == vtq_pkg::OP_RESOLVE)
                    begin
                        state_next = vtq_pkg::ST_WALK;
                    end
                    else if ((req.opcode == vtq_pkg::OP_READ) && in_range)
                    begin
                        state_next = vtq_pkg::ST_FETCH;
                    end
                end
            end
            vtq_pkg::ST_WALK:
            begin
                count_next = count_reg + CW'(step_hit);
                k_next     = k_reg + AW'(1);
                if (k_reg == AW'(LAST))
                begin
                    state_next = vtq_pkg::ST_DONE;
                    if (pos_reg)
                    begin
                        res_add_next = vtq_pkg::OCODE_W'(code_full);
                    end
                    else
                    begin
                        res_sub_next = vtq_pkg::OCODE_W'(code_full);
                    end
                end
            end
            vtq_pkg::ST_FETCH:
            begin
                res_delay_next = eff;
                state_next     = vtq_pkg::ST_DONE;
            end
            vtq_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = vtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vtq_pkg::ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        pos_reg       <= pos_next;
        side_reg      <= side_next;
        addr_reg      <= addr_next;
        res_add_reg   <= res_add_next;
        res_sub_reg   <= res_sub_next;
        res_delay_reg <= res_delay_next;
        if (state_reg == vtq_pkg::ST_WALK)
        begin
            sum_reg <= sum_next;
        end
        else
        begin
            sum_reg <= '0;
        end
        if (out_load)
        begin
            out_add_reg   <= res_add_reg;
            out_sub_reg   <= res_sub_reg;
            out_delay_reg <= res_delay_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.add_code    = out_add_reg;
    assign rsp.sub_code    = out_sub_reg;
    assign rsp.delay_value = out_delay_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vtq_pkg::ST_CLEAR) |-> !req.ready)
        else $error("request accepted during RAM clear");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vtq_pkg::ST_WALK) |=>
        ((count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1))))
        else $error("stage count moved by more than one");

    a_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (plus_we || minus_we) |->
        ((state_reg == vtq_pkg::ST_IDLE) || (state_reg == vtq_pkg::ST_CLEAR)))
        else $error("correction RAM written during a walk");

    a_one_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.add_code == '0) || (rsp.sub_code == '0)))
        else $error("both codes set in one result");
`endif

endmodule

[sim/vtq_checker.sv]
module vtq_checker
    import vtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    vtq_req_if          req,
    vtq_rsp_if          rsp,
    output int          mismatch_count,
    output int          results_due
);

    localparam int CODE_BITS = 8;
    localparam int STAGES    = 128;
    localparam int COUNT_MAX = (1 << (CODE_BITS - 1)) - 1;
    localparam logic [2:0] STAGE_DELAY_ADDR = {REG_STAGE_DELAY, 2'b00};

    typedef struct packed {
        logic [OCODE_W-1:0]       add_code;
        logic [OCODE_W-1:0]       sub_code;
        logic signed [EFF_W-1:0]  delay_value;
    } tdc_result_t;

    logic signed [TIME_W-1:0] stage_delay;
    logic signed [CORR_W-1:0] plus_corr  [STAGES];
    logic signed [CORR_W-1:0] minus_corr [STAGES];
    tdc_result_t              expected_codes [$];

    function automatic longint stage_effective(logic side, int k);
        longint nominal;
        if (side)
            return -longint'(stage_delay) + longint'(minus_corr[k]);
        if (k == 0)
            nominal = longint'(STAGE0_NOMINAL);
        else if (k == 1)
            nominal = longint'(STAGE1_NOMINAL);
        else
            nominal = longint'(stage_delay);
        return nominal + longint'(plus_corr[k]);
    endfunction

    function automatic tdc_result_t quantize_time(logic signed [TIME_W-1:0] t);
        tdc_result_t r;
        longint      sum;
        int          count;
        logic        positive;
        r        = '0;
        sum      = 0;
        count    = 0;
        positive = (t > 0);
        for (int k = 0; k < COUNT_MAX && k < STAGES; k++)
        begin
            sum += stage_effective(!positive, k);
            if (positive ? (longint'(t) > sum) : (longint'(t) < sum))
                count++;
        end
        if (count > COUNT_MAX)
            count = COUNT_MAX;
        if (positive)
            r.add_code = OCODE_W'((1 << (CODE_BITS - 1)) | count);
        else
            r.sub_code = OCODE_W'((1 << (CODE_BITS - 1)) | count);
        return r;
    endfunction

    task automatic compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tdc_result_t want;
        tdc_result_t got;
        if (!rst_n)
        begin
            stage_delay = STAGE_DELAY_RESET;
            for (int k = 0; k < STAGES; k++)
            begin
                plus_corr[k]  = '0;
                minus_corr[k] = '0;
            end
            expected_codes.delete();
            mismatch_count = 0;
            results_due    = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                want = '0;
                case (req.opcode)
                    OP_RESOLVE: want = quantize_time(req.time_in);
                    OP_WRITE:
                    begin
                        if (req.corr_side)
                            minus_corr[req.stage_index] = req.corr_value;
                        else
                            plus_corr[req.stage_index] = req.corr_value;
                    end
                    OP_READ:
                        want.delay_value = EFF_W'(stage_effective(req.corr_side,
                                                                  req.stage_index));
                    default: ;
                endcase
                expected_codes.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got.add_code    = rsp.add_code;
                got.sub_code    = rsp.sub_code;
                got.delay_value = rsp.delay_value;
                if (expected_codes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request pending: add %0d sub %0d delay %0d",
                                 $realtime, got.add_code, got.sub_code, got.delay_value);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    compare_field("add_code", want.add_code, got.add_code);
                    compare_field("sub_code", want.sub_code, got.sub_code);
                    compare_field("delay_value", want.delay_value, got.delay_value);
                end
            end
            if (psel && penable && pwrite && pready && paddr == STAGE_DELAY_ADDR)
                stage_delay = pwdata[TIME_W-1:0];
            results_due = expected_codes.size();
        end
    end

endmodule

[sim/tb.sv]
module tb;
    import vtq_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int MAX_TIME        = 524287;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vtq_req_if req_bus ();
    vtq_rsp_if rsp_bus ();

    int mismatch_count;
    int results_due;
    int cycles;
    bit gaps_on;
    int phase_delay [PHASES] = '{256, 0, 524287, -524288, 1, -300, 37, 256};

    vernier_tdc_quantizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    vtq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    task automatic send_request(opcode_t op, logic signed [TIME_W-1:0] t,
                                logic signed [CORR_W-1:0] corr, logic side,
                                logic [INDEX_W-1:0] index);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.time_in     <= t;
        req_bus.corr_value  <= corr;
        req_bus.corr_side   <= side;
        req_bus.stage_index <= index;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
    endtask

    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_stage_delay(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STAGE_DELAY, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_request(int delay);
        opcode_t                  op;
        logic signed [TIME_W-1:0] t;
        logic signed [CORR_W-1:0] corr;
        logic [INDEX_W-1:0]       index;
        int                       pick;
        int                       reach;
        int                       magnitude;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_RESOLVE;
        else if (pick < 75)
            op = OP_WRITE;
        else if (pick < 95)
            op = OP_READ;
        else
            op = OP_UNUSED;
        magnitude = (delay < 0) ? -delay : delay;
        reach = magnitude * 130 + 2048;
        if (reach > MAX_TIME)
            reach = MAX_TIME;
        if ($urandom_range(0, 7) == 0)
            t = TIME_W'($urandom);
        else if ($urandom_range(0, 1) == 0)
            t = TIME_W'($urandom_range(0, reach));
        else
            t = TIME_W'(-int'($urandom_range(0, reach)));
        pick = $urandom_range(0, 7);
        if (pick == 0)
            corr = CORR_W'($urandom);
        else if (pick == 1)
            corr = '0;
        else
            corr = CORR_W'(int'($urandom_range(0, 512)) - 256);
        if ($urandom_range(0, 3) == 0)
            index = INDEX_W'($urandom_range(0, 3));
        else
            index = INDEX_W'($urandom_range(0, 127));
        send_request(op, t, corr, 1'($urandom_range(0, 1)), index);
    endtask

    initial
    begin
        gaps_on             <= 1'b0;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.opcode      <= OP_RESOLVE;
        req_bus.time_in     <= '0;
        req_bus.corr_value  <= '0;
        req_bus.corr_side   <= 1'b0;
        req_bus.stage_index <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on <= 1'b1;
        send_request(OP_RESOLVE, 20'sd0, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd1, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, -20'sd1, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd524287, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, -20'sd524288, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd768, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd769, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd1025, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, -20'sd256, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, -20'sd257, '0, 1'b0, 7'd0);
        send_request(OP_WRITE, '0, 20'sd524287, 1'b0, 7'd0);
        send_request(OP_READ, '0, '0, 1'b0, 7'd0);
        send_request(OP_RESOLVE, 20'sd524287, '0, 1'b0, 7'd0);
        send_request(OP_WRITE, '0, -20'sd524288, 1'b1, 7'd127);
        send_request(OP_READ, '0, '0, 1'b1, 7'd127);
        send_request(OP_RESOLVE, -20'sd524288, '0, 1'b0, 7'd0);
        send_request(OP_READ, '0, '0, 1'b0, 7'd1);
        send_request(OP_READ, '0, '0, 1'b0, 7'd127);
        send_request(OP_WRITE, '0, '0, 1'b0, 7'd0);
        send_request(OP_WRITE, '0, '0, 1'b1, 7'd127);
        send_request(OP_UNUSED, -20'sd1, -20'sd1, 1'b1, 7'd127);
        send_request(OP_WRITE, '0, -20'sd1, 1'b1, 7'd5);
        send_request(OP_READ, '0, '0, 1'b1, 7'd5);
        send_request(OP_RESOLVE, -20'sd1536, '0, 1'b0, 7'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            write_stage_delay(phase_delay[phase]);
            @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == PHASES - 1)
                    gaps_on <= 1'b0;
                else if (n % 40 == 0)
                    gaps_on <= ($urandom_range(0, 3) != 0);
                send_random_request(phase_delay[phase]);
            end
        end

        wait_for_results();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
